>>> hw/rtl/qapm_pkg.sv
// ----------------------------------------------------------------------------
// qapm_pkg
// Shared widths, register indexes and types for the attitude controller and
// X mixer.
// ----------------------------------------------------------------------------
package qapm_pkg;

    localparam int AXES       = 4;
    localparam int ANGLE_W    = 16;              // width of an angle field
    localparam int ANGLE_BITS = 16;              // bits of each angle in use
    localparam int ERR_W      = ANGLE_BITS + 1;
    localparam int DIF_W      = ERR_W + 1;
    localparam int GAIN_W     = 16;
    localparam int GAINS_W    = 3 * GAIN_W;
    localparam int PROD_W     = GAIN_W + DIF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int TERM_SHIFT = 15;
    localparam int SHR_W      = SUM_W - TERM_SHIFT;
    localparam int TERM_W     = 16;
    localparam int MIX_W      = TERM_W + 2;
    localparam int VAL_W      = MIX_W + 1;
    localparam int MOTOR_W    = 12;
    localparam int REF_SLOT_W = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_GAINS_ROLL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAINS_PITCH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAINS_YAW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAINS_LIFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX     = 3'd7;

    localparam logic [GAINS_W-1:0]    GAINS_PITCH_RST = 48'h0000_0200_0280;
    localparam logic [GAINS_W-1:0]    TRIM_RST        = 48'h5DC_5DC_5DC_5C8;
    localparam logic [MOTOR_W-1:0]    OUT_MIN_RST     = 12'd1000;
    localparam logic [MOTOR_W-1:0]    OUT_MAX_RST     = 12'd2000;

    localparam int AX_ROLL  = 0;
    localparam int AX_PITCH = 1;
    localparam int AX_YAW   = 2;
    localparam int AX_LIFT  = 3;

    typedef struct packed {
        logic load_prod;   // take new products
        logic load_term;   // take new saturated term
    } qapm_lane_ctrl_t;

    typedef struct packed {
        logic load;        // output register takes a beat
        logic upd;         // beat recomputes the motors
    } qapm_mix_ctrl_t;

endpackage

>>> hw/rtl/qapm_if.sv
// ----------------------------------------------------------------------------
// qapm channel interfaces
// Valid/ready channels for the angle beats and the motor beats.
// ----------------------------------------------------------------------------
interface qapm_in_if;
    import qapm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle_roll;
    logic signed [ANGLE_W-1:0] angle_pitch;
    logic signed [ANGLE_W-1:0] angle_yaw;
    logic signed [ANGLE_W-1:0] angle_lift;

    modport source (output valid, angle_roll, angle_pitch, angle_yaw, angle_lift,
                    input ready);
    modport sink   (input valid, angle_roll, angle_pitch, angle_yaw, angle_lift,
                    output ready);
endinterface

interface qapm_out_if;
    import qapm_pkg::*;
    logic               valid;
    logic               ready;
    logic [MOTOR_W-1:0] motor_one;
    logic [MOTOR_W-1:0] motor_two;
    logic [MOTOR_W-1:0] motor_three;
    logic [MOTOR_W-1:0] motor_four;
    logic               updated;

    modport source (output valid, motor_one, motor_two, motor_three, motor_four,
                    updated, input ready);
    modport sink   (input valid, motor_one, motor_two, motor_three, motor_four,
                    updated, output ready);
endinterface

>>> hw/rtl/qapm_lane.sv
// ----------------------------------------------------------------------------
// qapm_lane
// One axis: three gain products, then sum, truncate toward zero, saturate.
// ----------------------------------------------------------------------------
module qapm_lane
    import qapm_pkg::*;
(
    input  logic                      clk,
    input  logic [GAINS_W-1:0]        gains,
    input  logic signed [ERR_W-1:0]   err,
    input  logic signed [ERR_W-1:0]   prev,
    input  qapm_lane_ctrl_t           ctrl,
    output logic signed [TERM_W-1:0]  term
);

    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] kd;
    logic signed [GAIN_W-1:0] ki;
    logic signed [DIF_W-1:0]  err_x;
    logic signed [DIF_W-1:0]  dif;
    logic signed [DIF_W-1:0]  acc;

    logic signed [PROD_W-1:0] prod_p_reg;
    logic signed [PROD_W-1:0] prod_d_reg;
    logic signed [PROD_W-1:0] prod_i_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  biased;
    logic signed [SHR_W-1:0]  shr;
    logic signed [TERM_W-1:0] term_next;
    logic signed [TERM_W-1:0] term_reg;

    assign kp    = signed'(gains[GAIN_W-1:0]);
    assign kd    = signed'(gains[2*GAIN_W-1:GAIN_W]);
    assign ki    = signed'(gains[3*GAIN_W-1:2*GAIN_W]);
    assign err_x = DIF_W'(err);
    assign dif   = err_x - DIF_W'(prev);
    assign acc   = err_x + DIF_W'(prev);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            prod_p_reg <= PROD_W'(kp * err_x);
            prod_d_reg <= PROD_W'(kd * dif);
            prod_i_reg <= PROD_W'(ki * acc);
        end
    end

    // round toward zero: bias negative sums before the arithmetic shift
    always_comb
    begin
        sum    = SUM_W'(prod_p_reg) + SUM_W'(prod_d_reg) + SUM_W'(prod_i_reg);
        biased = sum + (sum[SUM_W-1] ? SUM_W'((1 << TERM_SHIFT) - 1) : SUM_W'(0));
        shr    = SHR_W'(biased >>> TERM_SHIFT);
        if (shr > SHR_W'((1 << (TERM_W - 1)) - 1))
            term_next = TERM_W'((1 << (TERM_W - 1)) - 1);
        else if (shr < -SHR_W'(1 << (TERM_W - 1)))
            term_next = TERM_W'(-(1 << (TERM_W - 1)));
        else
            term_next = TERM_W'(shr);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_term)
            term_reg <= term_next;
    end

    assign term = term_reg;

endmodule

>>> hw/rtl/qapm_mixer.sv
// ----------------------------------------------------------------------------
// qapm_mixer
// X mixer: combine lane terms with trims, clamp, hold last motor values.
// ----------------------------------------------------------------------------
module qapm_mixer
    import qapm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [TERM_W-1:0]  term_roll,
    input  logic signed [TERM_W-1:0]  term_pitch,
    input  logic signed [TERM_W-1:0]  term_lift,
    input  logic [GAINS_W-1:0]        trim,
    input  logic [MOTOR_W-1:0]        out_min,
    input  logic [MOTOR_W-1:0]        out_max,
    input  qapm_mix_ctrl_t            ctrl,
    output logic [MOTOR_W-1:0]        motor [AXES]
);

    logic signed [MIX_W-1:0]   mix   [AXES];
    logic [MOTOR_W-1:0]        clamp [AXES];
    logic [MOTOR_W-1:0]        held_reg  [AXES];
    logic [MOTOR_W-1:0]        motor_reg [AXES];
    logic signed [MIX_W-1:0]   r;
    logic signed [MIX_W-1:0]   p;
    logic signed [MIX_W-1:0]   l;

    assign r = MIX_W'(term_roll);
    assign p = MIX_W'(term_pitch);
    assign l = MIX_W'(term_lift);

    // the yaw term is not wired in, so it drops out of every motor
    assign mix[0] = l - p - r;
    assign mix[1] = l + p - r;
    assign mix[2] = l - p + r;
    assign mix[3] = l + p + r;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            logic signed [VAL_W-1:0] v;
            v = signed'(VAL_W'(trim[i*MOTOR_W +: MOTOR_W])) + VAL_W'(mix[i]);
            if (v > signed'(VAL_W'(out_max)))
                clamp[i] = out_max;
            else if (v < signed'(VAL_W'(out_min)))
                clamp[i] = out_min;
            else
                clamp[i] = MOTOR_W'(v);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
                held_reg[i] <= '0;
        end
        else if (ctrl.load && ctrl.upd)
        begin
            for (int i = 0; i < AXES; i++)
                held_reg[i] <= clamp[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < AXES; i++)
                motor_reg[i] <= ctrl.upd ? clamp[i] : held_reg[i];
        end
    end

    assign motor = motor_reg;

endmodule

>>> hw/rtl/quad_attitude_pd_mixer_top.sv
// An accepted angle beat passes the error stage, the lanes and the mixer output
// register. Throughput: one beat per cycle while the output is not stalled; the
// roll-error compare and the error update sit in the first stage, so each beat
// sees the last recomputed beat's errors. Four axis lanes multiply in parallel;
// the mixer stage merges their terms. Reset: registers take their reset values,
// previous errors and held motors clear, the pipeline empties; no clearing pass.
// ----------------------------------------------------------------------------
// quad_attitude_pd_mixer_top
// Attitude controller with X mixer: error stage, four lanes, mixer stage.
// ----------------------------------------------------------------------------
module quad_attitude_pd_mixer_top
    import qapm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    qapm_in_if.sink                in_ch,
    qapm_out_if.source             out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [GAINS_W-1:0]     gains_reg [AXES];
    logic [CFG_DATA_W-1:0]  reference_reg;
    logic [GAINS_W-1:0]     trim_reg;
    logic [MOTOR_W-1:0]     out_min_reg;
    logic [MOTOR_W-1:0]     out_max_reg;

    logic signed [ERR_W-1:0] prev_err_reg [AXES];
    logic signed [ERR_W-1:0] err          [AXES];
    logic [ANGLE_W-1:0]      angle        [AXES];

    logic signed [ERR_W-1:0] s1_err_reg  [AXES];
    logic signed [ERR_W-1:0] s1_prev_reg [AXES];
    logic                    s1_upd_reg, s2_upd_reg, s3_upd_reg, s4_upd_reg;
    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic                    r1, r2, r3, r4;
    logic                    in_acc;
    logic                    skip;
    logic                    gain_wr;

    logic signed [TERM_W-1:0] term [AXES];
    logic [MOTOR_W-1:0]       motor [AXES];
    qapm_lane_ctrl_t          lane_ctrl;
    qapm_mix_ctrl_t           mix_ctrl;

    assign angle[AX_ROLL]  = in_ch.angle_roll;
    assign angle[AX_PITCH] = in_ch.angle_pitch;
    assign angle[AX_YAW]   = in_ch.angle_yaw;
    assign angle[AX_LIFT]  = in_ch.angle_lift;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            err[i] = ERR_W'(signed'(reference_reg[i*REF_SLOT_W +: ANGLE_BITS]))
                   - ERR_W'(signed'(angle[i][ANGLE_BITS-1:0]));
        end
    end

    // each stage moves when its successor is empty or moving
    assign r4 = !v4_reg || out_ch.ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ch.ready = r1;
    assign in_acc  = in_ch.valid && r1;
    assign skip    = (err[AX_ROLL] == prev_err_reg[AX_ROLL]);
    assign gain_wr = cfg_we && (cfg_index == REG_GAINS_ROLL || cfg_index == REG_GAINS_PITCH
                             || cfg_index == REG_GAINS_YAW || cfg_index == REG_GAINS_LIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg[AX_ROLL]  <= '0;
            gains_reg[AX_PITCH] <= GAINS_PITCH_RST;
            gains_reg[AX_YAW]   <= '0;
            gains_reg[AX_LIFT]  <= '0;
            reference_reg       <= '0;
            trim_reg            <= TRIM_RST;
            out_min_reg         <= OUT_MIN_RST;
            out_max_reg         <= OUT_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAINS_ROLL:  gains_reg[AX_ROLL]  <= cfg_wdata[GAINS_W-1:0];
                REG_GAINS_PITCH: gains_reg[AX_PITCH] <= cfg_wdata[GAINS_W-1:0];
                REG_GAINS_YAW:   gains_reg[AX_YAW]   <= cfg_wdata[GAINS_W-1:0];
                REG_GAINS_LIFT:  gains_reg[AX_LIFT]  <= cfg_wdata[GAINS_W-1:0];
                REG_REFERENCE:   reference_reg       <= cfg_wdata;
                REG_TRIM:        trim_reg            <= cfg_wdata[GAINS_W-1:0];
                REG_OUT_MIN:     out_min_reg         <= cfg_wdata[MOTOR_W-1:0];
                REG_OUT_MAX:     out_max_reg         <= cfg_wdata[MOTOR_W-1:0];
                default:         ;
            endcase
        end
    end

    // previous errors: cleared by a gain write, else advanced by a recomputed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
                prev_err_reg[i] <= '0;
        end
        else if (gain_wr)
        begin
            for (int i = 0; i < AXES; i++)
                prev_err_reg[i] <= '0;
        end
        else if (in_acc && !skip)
        begin
            for (int i = 0; i < AXES; i++)
                prev_err_reg[i] <= err[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_ch.valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            s1_upd_reg <= !skip;
            for (int i = 0; i < AXES; i++)
            begin
                s1_err_reg[i]  <= err[i];
                s1_prev_reg[i] <= prev_err_reg[i];
            end
        end
        if (r2)
            s2_upd_reg <= s1_upd_reg;
        if (r3)
            s3_upd_reg <= s2_upd_reg;
        if (r4)
            s4_upd_reg <= s3_upd_reg;
    end

    assign lane_ctrl.load_prod = r2;
    assign lane_ctrl.load_term = r3;

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        qapm_lane u_lane (
            .clk   (clk),
            .gains (gains_reg[g]),
            .err   (s1_err_reg[g]),
            .prev  (s1_prev_reg[g]),
            .ctrl  (lane_ctrl),
            .term  (term[g])
        );
    end

    assign mix_ctrl.load = r4 && v3_reg;
    assign mix_ctrl.upd  = s3_upd_reg;

    qapm_mixer u_mixer (
        .clk        (clk),
        .rst_n      (rst_n),
        .term_roll  (term[AX_ROLL]),
        .term_pitch (term[AX_PITCH]),
        .term_lift  (term[AX_LIFT]),
        .trim       (trim_reg),
        .out_min    (out_min_reg),
        .out_max    (out_max_reg),
        .ctrl       (mix_ctrl),
        .motor      (motor)
    );

    assign out_ch.valid       = v4_reg;
    assign out_ch.motor_one   = motor[0];
    assign out_ch.motor_two   = motor[1];
    assign out_ch.motor_three = motor[2];
    assign out_ch.motor_four  = motor[3];
    assign out_ch.updated     = s4_upd_reg;

endmodule

>>> hw/rtl/qapm_checker.sv
// ----------------------------------------------------------------------------
// qapm_checker
// Port-level checks on the controller's channels, bound to the top level.
// ----------------------------------------------------------------------------
module qapm_checker
    import qapm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [MOTOR_W-1:0] motor_one,
    input  logic               updated
);

    // an empty output register lets the whole pipeline advance
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register empty");

    // an accepted beat reaches the output unless the output stalls or reset falls
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(in_valid && in_ready, 4) && $past(out_ready, 3) && $past(out_ready, 2)
         && $past(out_ready, 1) && $past(rst_n, 1) && $past(rst_n, 2)
         && $past(rst_n, 3) && $past(rst_n, 4)) |-> out_valid)
        else $error("accepted beat did not reach the output in time");

    // a stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(motor_one) && $stable(updated)))
        else $error("stalled output beat changed");

endmodule

bind quad_attitude_pd_mixer_top qapm_checker u_qapm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .motor_one (out_ch.motor_one),
    .updated   (out_ch.updated)
);

>>> test/quad_attitude_pd_mixer_top_tb.sv
// ----------------------------------------------------------------------------
// quad_attitude_pd_mixer_top_tb
// Self-checking bench for the attitude controller and X mixer. Angle beats go
// in over a valid/ready channel with random gaps, and motor beats are taken
// with random back-pressure. A scoreboard class keeps its own copy of the
// gains, references, trims, limits, previous errors and held motors, predicts
// each motor beat and checks it field by field. A short directed part covers
// the unchanged-roll hold, extreme angles and gains, saturated terms, negative
// mixer sums and crossed limits; random setups and angle streams follow.
// ----------------------------------------------------------------------------
module quad_attitude_pd_mixer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qapm_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int DRAIN_CYC  = 8;      // quiet time after the last motor beat
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 10;
    localparam int PHASE_BEATS = 130;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_roll;
        logic signed [ANGLE_W-1:0] angle_pitch;
        logic signed [ANGLE_W-1:0] angle_yaw;
        logic signed [ANGLE_W-1:0] angle_lift;
    } angles_t;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_one;
        logic [MOTOR_W-1:0] motor_two;
        logic [MOTOR_W-1:0] motor_three;
        logic [MOTOR_W-1:0] motor_four;
        logic               updated;
    } motors_t;

    class mixer_scoreboard;
        logic [GAINS_W-1:0]    gains [AXES];
        logic [CFG_DATA_W-1:0] refs;
        logic [GAINS_W-1:0]    trims;
        logic [MOTOR_W-1:0]    lo;
        logic [MOTOR_W-1:0]    hi;
        longint                prev_err [AXES];
        logic [MOTOR_W-1:0]    held [AXES];
        motors_t               pending_motors [$];
        int                    errors;
        int                    n_angles;
        int                    n_updated;
        int                    n_held;

        function new();
            foreach (gains[i])
            begin
                gains[i]    = '0;
                prev_err[i] = 0;
                held[i]     = '0;
            end
            gains[AX_PITCH] = GAINS_PITCH_RST;
            refs      = '0;
            trims     = TRIM_RST;
            lo        = OUT_MIN_RST;
            hi        = OUT_MAX_RST;
            errors    = 0;
            n_angles  = 0;
            n_updated = 0;
            n_held    = 0;
        endfunction

        task report(string msg);
            if (errors < 200)
                $display("tb: mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAINS_ROLL, REG_GAINS_PITCH, REG_GAINS_YAW, REG_GAINS_LIFT:
                begin
                    gains[int'(idx)] = data[GAINS_W-1:0];
                    // any gain write forgets the error history
                    foreach (prev_err[i])
                        prev_err[i] = 0;
                end
                REG_REFERENCE: refs  = data;
                REG_TRIM:      trims = data[GAINS_W-1:0];
                REG_OUT_MIN:   lo    = data[MOTOR_W-1:0];
                REG_OUT_MAX:   hi    = data[MOTOR_W-1:0];
                default:       ;
            endcase
        endfunction

        function longint axis_term(logic [GAINS_W-1:0] g, longint e, longint p);
            longint kp;
            longint kd;
            longint ki;
            longint s;
            longint t;
            kp = longint'($signed(g[GAIN_W-1:0]));
            kd = longint'($signed(g[2*GAIN_W-1:GAIN_W]));
            ki = longint'($signed(g[3*GAIN_W-1:2*GAIN_W]));
            s  = kp * e + kd * (e - p) + ki * (e + p);
            // truncate toward zero, then saturate to 16 bits
            if (s < 0)
                t = -((-s) >>> TERM_SHIFT);
            else
                t = s >>> TERM_SHIFT;
            if (t > 32767)
                t = 32767;
            if (t < -32768)
                t = -32768;
            return t;
        endfunction

        function void note_angles(angles_t a);
            longint  ang [AXES];
            longint  err [AXES];
            longint  term [AXES];
            longint  mix [AXES];
            longint  v;
            motors_t m;
            ang[AX_ROLL]  = longint'($signed(a.angle_roll));
            ang[AX_PITCH] = longint'($signed(a.angle_pitch));
            ang[AX_YAW]   = longint'($signed(a.angle_yaw));
            ang[AX_LIFT]  = longint'($signed(a.angle_lift));
            for (int i = 0; i < AXES; i++)
                err[i] = longint'($signed(refs[REF_SLOT_W*i +: REF_SLOT_W])) - ang[i];
            n_angles++;
            if (err[AX_ROLL] == prev_err[AX_ROLL])
            begin
                // roll error unchanged: hold everything
                m.updated = 1'b0;
                n_held++;
            end
            else
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    term[i]     = axis_term(gains[i], err[i], prev_err[i]);
                    prev_err[i] = err[i];
                end
                term[AX_YAW] = 0;
                mix[0] = term[AX_LIFT] - term[AX_PITCH] - term[AX_ROLL] - term[AX_YAW];
                mix[1] = term[AX_LIFT] + term[AX_PITCH] - term[AX_ROLL] + term[AX_YAW];
                mix[2] = term[AX_LIFT] - term[AX_PITCH] + term[AX_ROLL] + term[AX_YAW];
                mix[3] = term[AX_LIFT] + term[AX_PITCH] + term[AX_ROLL] - term[AX_YAW];
                for (int i = 0; i < AXES; i++)
                begin
                    v = longint'(trims[MOTOR_W*i +: MOTOR_W]) + mix[i];
                    // with crossed limits, sums above the upper limit take it, the rest the lower
                    if (v > longint'(hi))
                        v = longint'(hi);
                    else if (v < longint'(lo))
                        v = longint'(lo);
                    held[i] = v[MOTOR_W-1:0];
                end
                m.updated = 1'b1;
                n_updated++;
            end
            m.motor_one   = held[0];
            m.motor_two   = held[1];
            m.motor_three = held[2];
            m.motor_four  = held[3];
            pending_motors.push_back(m);
        endfunction

        task check_motors(motors_t got);
            motors_t want;
            if (pending_motors.size() == 0)
            begin
                report("motor beat with no angle beat waiting");
                return;
            end
            want = pending_motors.pop_front();
            if (got.motor_one !== want.motor_one)
                report($sformatf("motor_one %0d, want %0d", got.motor_one, want.motor_one));
            if (got.motor_two !== want.motor_two)
                report($sformatf("motor_two %0d, want %0d", got.motor_two, want.motor_two));
            if (got.motor_three !== want.motor_three)
                report($sformatf("motor_three %0d, want %0d",
                                 got.motor_three, want.motor_three));
            if (got.motor_four !== want.motor_four)
                report($sformatf("motor_four %0d, want %0d", got.motor_four, want.motor_four));
            if (got.updated !== want.updated)
                report($sformatf("updated %0b, want %0b", got.updated, want.updated));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    bit                    calm;
    int                    idle_cycles;
    int                    n_writes;
    logic [ANGLE_W-1:0]    last_roll;
    logic [CFG_DATA_W-1:0] setup [8];

    mixer_scoreboard sb = new();

    qapm_in_if  in_ch ();
    qapm_out_if out_ch ();

    quad_attitude_pd_mixer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 7);

    // note inputs before checking outputs so the order within the edge is fixed
    always @(posedge clk)
    begin : monitor
        angles_t a;
        motors_t m;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                a.angle_roll  = in_ch.angle_roll;
                a.angle_pitch = in_ch.angle_pitch;
                a.angle_yaw   = in_ch.angle_yaw;
                a.angle_lift  = in_ch.angle_lift;
                sb.note_angles(a);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                m.motor_one   = out_ch.motor_one;
                m.motor_two   = out_ch.motor_two;
                m.motor_three = out_ch.motor_three;
                m.motor_four  = out_ch.motor_four;
                m.updated     = out_ch.updated;
                sb.check_motors(m);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: no beat for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_angles(logic [ANGLE_W-1:0] r, logic [ANGLE_W-1:0] p,
                               logic [ANGLE_W-1:0] y, logic [ANGLE_W-1:0] l);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.angle_roll  <= r;
        in_ch.angle_pitch <= p;
        in_ch.angle_yaw   <= y;
        in_ch.angle_lift  <= l;
        last_roll = r;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        n_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // drop valid, drain the pipeline and let it go quiet
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending_motors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic apply_setup(bit [7:0] mask);
        for (int i = 0; i < 8; i++)
            if (mask[i])
                write_reg(CFG_IDX_W'(i), setup[i]);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 1536)) - 16'd768;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle(logic [ANGLE_W-1:0] centre);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return centre + 16'($urandom_range(0, 512)) - 16'd256;
            9:             return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default:       return 16'($urandom);
        endcase
    endfunction

    task automatic random_setup();
        logic [MOTOR_W-1:0] a;
        logic [MOTOR_W-1:0] b;
        bit   [7:0]         mask;
        mask = 8'hF0;
        for (int g = 0; g < AXES; g++)
        begin
            setup[g] = {16'($urandom), pick_gain(), pick_gain(), pick_gain()};
            if ($urandom_range(0, 1))
                mask[g] = 1'b1;
        end
        for (int s = 0; s < AXES; s++)
            setup[REG_REFERENCE][REF_SLOT_W*s +: REF_SLOT_W] =
                ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 4096)) - 16'd2048
                                           : 16'($urandom);
        setup[REG_TRIM] = {16'($urandom), 48'd0};
        for (int t = 0; t < AXES; t++)
            setup[REG_TRIM][MOTOR_W*t +: MOTOR_W] =
                ($urandom_range(0, 9) < 7) ? 12'($urandom_range(1300, 1700)) : 12'($urandom);
        a = 12'($urandom);
        b = 12'($urandom);
        case ($urandom_range(0, 4))
            0:
            begin
                a = 12'd1000;
                b = 12'd2000;
            end
            1:
            begin
                a = 12'd0;
                b = 12'd4095;
            end
            2:
            begin
                // crossed limits
                a = 12'($urandom_range(2048, 4095));
                b = 12'($urandom_range(0, 2047));
            end
            3:       b = a;
            default: ;
        endcase
        setup[REG_OUT_MIN] = {52'($urandom), a};
        setup[REG_OUT_MAX] = {52'($urandom), b};
        apply_setup(mask);
    endtask

    task automatic run_phase(int count);
        logic [ANGLE_W-1:0] r;
        logic [ANGLE_W-1:0] rr;
        int                 pick;
        for (int k = 0; k < count; k++)
        begin
            rr   = sb.refs[REF_SLOT_W*AX_ROLL +: REF_SLOT_W];
            pick = $urandom_range(0, 99);
            if (pick < 15)
                r = last_roll;
            else if (pick < 25)
                r = rr;
            else
                r = pick_angle(rr);
            send_angles(r,
                        pick_angle(sb.refs[REF_SLOT_W*AX_PITCH +: REF_SLOT_W]),
                        pick_angle(sb.refs[REF_SLOT_W*AX_YAW +: REF_SLOT_W]),
                        pick_angle(sb.refs[REF_SLOT_W*AX_LIFT +: REF_SLOT_W]));
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.angle_roll  = '0;
        in_ch.angle_pitch = '0;
        in_ch.angle_yaw   = '0;
        in_ch.angle_lift  = '0;
        out_ch.ready      = 1'b0;
        calm              = 1'b0;
        idle_cycles       = 0;
        n_writes          = 0;
        last_roll         = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setup: zero roll error right after reset returns zeros, held
        send_angles(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_angles(16'h0001, 16'h0064, 16'h0000, 16'h0000);
        send_angles(16'h0001, 16'hFF00, 16'h1234, 16'h0100);
        send_angles(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_angles(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_angles(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        settle();

        // extreme gains and references: terms saturate, wide limits
        setup[REG_GAINS_ROLL]  = 64'h0000_7FFF_8000_7FFF;
        setup[REG_GAINS_PITCH] = 64'h0000_7FFF_8000_7FFF;
        setup[REG_GAINS_YAW]   = 64'h0000_7FFF_7FFF_7FFF;
        setup[REG_GAINS_LIFT]  = 64'h0000_7FFF_8000_7FFF;
        setup[REG_REFERENCE]   = 64'h8000_7FFF_0000_7FFF;
        setup[REG_TRIM]        = 64'h0000_FFFF_FFFF_FFFF;
        setup[REG_OUT_MIN]     = 64'd0;
        setup[REG_OUT_MAX]     = 64'd4095;
        apply_setup(8'hFF);
        send_angles(16'h8000, 16'h7FFF, 16'h0000, 16'h8000);
        send_angles(16'h7FFF, 16'h8000, 16'h0005, 16'h7FFF);
        send_angles(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_angles(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
        send_angles(16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000);
        settle();

        // negative extreme gains, zero trims, crossed limits
        setup[REG_GAINS_ROLL]  = 64'hFFFF_8000_8000_8000;
        setup[REG_GAINS_PITCH] = 64'hFFFF_8000_8000_8000;
        setup[REG_GAINS_YAW]   = 64'hFFFF_8000_8000_8000;
        setup[REG_GAINS_LIFT]  = 64'hFFFF_8000_8000_8000;
        setup[REG_REFERENCE]   = 64'h0000_0000_0000_0000;
        setup[REG_TRIM]        = 64'h0000_0000_0000_0000;
        setup[REG_OUT_MIN]     = 64'd3000;
        setup[REG_OUT_MAX]     = 64'd500;
        apply_setup(8'hFF);
        send_angles(16'h0100, 16'h0000, 16'h0000, 16'h0000);
        send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_angles(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_angles(16'h0003, 16'hFFF0, 16'h0010, 16'h0020);
        send_angles(16'h0001, 16'h0000, 16'h0000, 16'hFFFF);
        settle();

        // modest gains, yaw gains set but its term must vanish
        setup[REG_GAINS_ROLL]  = 64'h0000_0040_0100_0200;
        setup[REG_GAINS_PITCH] = 64'h0000_0040_0100_0200;
        setup[REG_GAINS_YAW]   = 64'h0000_0100_0100_0100;
        setup[REG_GAINS_LIFT]  = 64'h0000_0080_0000_0180;
        setup[REG_TRIM]        = 64'h0000_5DC5_DC5D_C5DC;
        setup[REG_OUT_MIN]     = 64'd1400;
        setup[REG_OUT_MAX]     = 64'd1600;
        apply_setup(8'hFF);
        send_angles(16'h0020, 16'hFFE0, 16'h4000, 16'h0010);
        send_angles(16'hFFC0, 16'h0040, 16'hC000, 16'hFFF0);
        send_angles(16'hFFC0, 16'h0100, 16'h0000, 16'h0000);
        send_angles(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            calm = (ph == 3 || ph == 4);
            random_setup();
            run_phase(PHASE_BEATS);
            settle();
        end

        $display("tb: %0d angle beats, %0d recomputed and %0d held motor beats",
                 sb.n_angles, sb.n_updated, sb.n_held);
        $display("tb: %0d register writes across %0d setups, %0d mismatches",
                 n_writes, PHASES + 3, sb.errors);
        if (sb.errors == 0 && sb.pending_motors.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
